// ===== design/array_linked_list_insert_core_defines.svh =====
// Assertion helpers for the core RTL file.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef ARRAY_LINKED_LIST_INSERT_CORE_DEFINES_SVH
`define ARRAY_LINKED_LIST_INSERT_CORE_DEFINES_SVH

// Same-cycle implication.
`define ALIL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alil assertion failed");

// Next-cycle implication.
`define ALIL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alil assertion failed");

`endif

// ===== design/alil_pkg.sv =====
`default_nettype none

package alil_pkg;

    // Default node store depth
    localparam int CAPACITY_DEF = 64;

    // Node value width
    localparam int VALUE_W = 32;

    // Enables for the two node memories
    typedef struct packed {
        logic val_we;
        logic val_re;
        logic nxt_we;
        logic nxt_re;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== design/alil_node_mem.sv =====
`default_nettype none

// Node store: value array and link array, one write and one registered read each.
module alil_node_mem #(
    parameter int CAPACITY = alil_pkg::CAPACITY_DEF
) (
    input  wire logic                                   clk,
    input  wire alil_pkg::mem_ctl_t                     ctl,
    input  wire logic [$clog2(CAPACITY)-1:0]            val_waddr,
    input  wire logic [alil_pkg::VALUE_W-1:0]           val_wdata,
    input  wire logic [$clog2(CAPACITY)-1:0]            val_raddr,
    output logic      [alil_pkg::VALUE_W-1:0]           val_rdata,
    input  wire logic [$clog2(CAPACITY)-1:0]            nxt_waddr,
    input  wire logic [$clog2(CAPACITY+1)-1:0]          nxt_wdata,
    input  wire logic [$clog2(CAPACITY)-1:0]            nxt_raddr,
    output logic      [$clog2(CAPACITY+1)-1:0]          nxt_rdata
);

    localparam int LW = $clog2(CAPACITY + 1);

    logic [alil_pkg::VALUE_W-1:0] val_mem [CAPACITY];
    logic [LW-1:0]                nxt_mem [CAPACITY];

    // Value memory
    always_ff @(posedge clk)
    begin
        if (ctl.val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (ctl.val_re)
        begin
            val_rdata <= val_mem[val_raddr];
        end
    end

    // Link memory; entry holds successor slot + 1, zero at the tail
    always_ff @(posedge clk)
    begin
        if (ctl.nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (ctl.nxt_re)
        begin
            nxt_rdata <= nxt_mem[nxt_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/alil_out_reg.sv =====
`default_nettype none

// Output holding register between the emit walk and the master side.
module alil_out_reg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [alil_pkg::VALUE_W-1:0]  value_in,
    input  wire logic                          tail_in,
    output logic                               free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [alil_pkg::VALUE_W-1:0]  m_tdata,
    output logic                               m_tlast
);

    logic valid_reg;
    logic valid_next;
    logic [alil_pkg::VALUE_W-1:0] data_reg;
    logic tail_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= value_in;
            tail_reg <= tail_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = tail_reg;

endmodule

`default_nettype wire

// ===== design/array_linked_list_insert_core.sv =====
`default_nettype none
`include "array_linked_list_insert_core_defines.svh"

// Channel    Signals                                       Contents
// s_axis     tvalid tready tdata[31:0] tlast               value; tlast = last
// m_axis     tvalid tready tdata[31:0] tlast               value_res; tlast = final_res
//
// Append: the first node is written alone; later ones add a link write to the old tail.
// Last request: value write, head read, then start if it becomes the new head; else
// per node after the head a link read and a value compare, two link writes, then start.
// Read-out: one node per cycle while the sink takes results; a stalled sink holds it.
// rst_n clears control state only; the node memories are not cleared.
// Input is taken only between batches, not during the walk or the read-out.
module array_linked_list_insert_core #(
    parameter int CAPACITY = alil_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] value_res
    output logic             m_axis_tlast    // final_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LINK   = 4'd1;
    localparam logic [3:0] S_HEAD   = 4'd2;
    localparam logic [3:0] S_NX     = 4'd3;
    localparam logic [3:0] S_VAL    = 4'd4;
    localparam logic [3:0] S_CMT1   = 4'd5;
    localparam logic [3:0] S_CMT2   = 4'd6;
    localparam logic [3:0] S_ESTART = 4'd7;
    localparam logic [3:0] S_EOUT   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;
    logic [LW-1:0] head_reg, head_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] t_reg, t_next;
    logic [LW-1:0] nx_reg, nx_next;
    logic signed [31:0] new_val_reg, new_val_next;

    alil_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0] val_waddr, val_raddr, nxt_waddr, nxt_raddr;
    logic [31:0]   val_wdata;
    logic [31:0]   val_rdata;
    logic [LW-1:0] nxt_wdata, nxt_rdata;

    logic out_load, out_free, out_tail;
    logic in_accept;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Sequencer: append, insert walk, link commit, read-out
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        slot_next    = slot_reg;
        t_next       = t_reg;
        nx_next      = nx_reg;
        new_val_next = new_val_reg;
        mem_ctl      = '0;
        val_waddr    = count_reg;
        val_wdata    = s_axis_tdata;
        val_raddr    = AW'(head_reg - LW'(1));
        nxt_waddr    = count_reg;
        nxt_wdata    = '0;
        nxt_raddr    = AW'(head_reg - LW'(1));
        out_load     = 1'b0;
        out_tail     = (nxt_rdata == '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    slot_next    = count_reg;
                    new_val_next = s_axis_tdata;
                    if (!s_axis_tlast)
                    begin
                        // Append at the tail unless only the slot kept for the last value is left
                        if (count_reg != AW'(CAPACITY - 1))
                        begin
                            mem_ctl.val_we = 1'b1;
                            mem_ctl.nxt_we = 1'b1;
                            count_next     = count_reg + AW'(1);
                            if (count_reg == '0)
                            begin
                                head_next = LW'(1);
                            end
                            else
                            begin
                                state_next = S_LINK;
                            end
                        end
                    end
                    else
                    begin
                        mem_ctl.val_we = 1'b1;
                        if (head_reg == '0)
                        begin
                            // Empty list: new node stands alone
                            mem_ctl.nxt_we = 1'b1;
                            head_next      = LW'(count_reg) + LW'(1);
                            state_next     = S_ESTART;
                        end
                        else
                        begin
                            mem_ctl.val_re = 1'b1;
                            state_next     = S_HEAD;
                        end
                    end
                end
            end

            S_LINK:
            begin
                // Previous tail points at the new node
                mem_ctl.nxt_we = 1'b1;
                nxt_waddr      = slot_reg - AW'(1);
                nxt_wdata      = LW'(slot_reg) + LW'(1);
                state_next     = S_IDLE;
            end

            S_HEAD:
            begin
                if ($signed(val_rdata) > new_val_reg)
                begin
                    // New value below the head's value becomes the head
                    mem_ctl.nxt_we = 1'b1;
                    nxt_waddr      = slot_reg;
                    nxt_wdata      = head_reg;
                    head_next      = LW'(slot_reg) + LW'(1);
                    state_next     = S_ESTART;
                end
                else
                begin
                    t_next         = AW'(head_reg - LW'(1));
                    mem_ctl.nxt_re = 1'b1;
                    nxt_raddr      = AW'(head_reg - LW'(1));
                    state_next     = S_NX;
                end
            end

            S_NX:
            begin
                nx_next = nxt_rdata;
                if (nxt_rdata == '0)
                begin
                    state_next = S_CMT1;
                end
                else
                begin
                    mem_ctl.val_re = 1'b1;
                    val_raddr      = AW'(nxt_rdata - LW'(1));
                    state_next     = S_VAL;
                end
            end

            S_VAL:
            begin
                if ($signed(val_rdata) > new_val_reg)
                begin
                    state_next = S_CMT1;
                end
                else
                begin
                    t_next         = AW'(nx_reg - LW'(1));
                    mem_ctl.nxt_re = 1'b1;
                    nxt_raddr      = AW'(nx_reg - LW'(1));
                    state_next     = S_NX;
                end
            end

            S_CMT1:
            begin
                mem_ctl.nxt_we = 1'b1;
                nxt_waddr      = slot_reg;
                nxt_wdata      = nx_reg;
                state_next     = S_CMT2;
            end

            S_CMT2:
            begin
                mem_ctl.nxt_we = 1'b1;
                nxt_waddr      = t_reg;
                nxt_wdata      = LW'(slot_reg) + LW'(1);
                state_next     = S_ESTART;
            end

            S_ESTART:
            begin
                mem_ctl.val_re = 1'b1;
                mem_ctl.nxt_re = 1'b1;
                state_next     = S_EOUT;
            end

            S_EOUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (nxt_rdata == '0)
                    begin
                        // Tail sent: clear the batch
                        head_next  = '0;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_ctl.val_re = 1'b1;
                        mem_ctl.nxt_re = 1'b1;
                        val_raddr      = AW'(nxt_rdata - LW'(1));
                        nxt_raddr      = AW'(nxt_rdata - LW'(1));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        t_reg       <= t_next;
        nx_reg      <= nx_next;
        new_val_reg <= new_val_next;
    end

    alil_node_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk       (clk),
        .ctl       (mem_ctl),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata),
        .nxt_waddr (nxt_waddr),
        .nxt_wdata (nxt_wdata),
        .nxt_raddr (nxt_raddr),
        .nxt_rdata (nxt_rdata)
    );

    alil_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .value_in (val_rdata),
        .tail_in  (out_tail),
        .free     (out_free),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

    // Checks
    `ALIL_ASSERT_NOW(a_head_count, state_reg == S_IDLE, (head_reg == '0) == (count_reg == '0))
    `ALIL_ASSERT_NOW(a_count_max, 1'b1, count_reg <= AW'(CAPACITY - 1))
    `ALIL_ASSERT_NEXT(a_last_busy, in_accept && s_axis_tlast, state_reg != S_IDLE)
    `ALIL_ASSERT_NOW(a_head_walk, state_reg == S_HEAD || state_reg == S_ESTART, head_reg != '0)

endmodule

`default_nettype wire
